[hdl/tfpsd_pkg.sv]
// Shared types and constants of the two-finger pinch and swipe detector.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package tfpsd_pkg;

  localparam int ThrW      = 10;
  localparam int SpcW      = 12;
  localparam int SwpW      = 12;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 2;

  localparam logic [ThrW-1:0] PinchThrRst = 10'd10;
  localparam logic [SpcW-1:0] SpacingRst  = 12'd120;
  localparam logic [SwpW-1:0] SwipeThrRst = 12'd80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PINCH_THRESHOLD   = 2'd0,
    CFG_SWIPE_MAX_SPACING = 2'd1,
    CFG_SWIPE_THRESHOLD   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_PRESSED    = 2'd0,
    PH_MOVED      = 2'd1,
    PH_STATIONARY = 2'd2,
    PH_RELEASED   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    MS_W       = 3'd0,
    MS_H       = 3'd1,
    MS_DX      = 3'd2,
    MS_DY      = 3'd3,
    MS_SPACING = 3'd4,
    MS_SWIPE   = 3'd5
  } mul_sel_e;

  typedef struct packed {
    logic [ThrW-1:0] pinch_threshold;
    logic [SpcW-1:0] swipe_max_spacing;
    logic [SwpW-1:0] swipe_threshold;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     diff;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     root_load;
    logic     root_step;
    logic     delta;
    logic     commit;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/tfpsd_ctrl.sv]
// Sequencing controller of the detector: accept, geometry, six squarings,
// digit-by-digit root, decision and result handoff. Uses tfpsd_pkg.
`default_nettype none

module tfpsd_ctrl #(
  parameter int COORD_BITS     = 16,
  parameter int DIST_FRAC_BITS = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire              out_ready_i,
  output logic             out_valid_o,
  output tfpsd_pkg::cmd_t  cmd_o
);
  import tfpsd_pkg::*;

  localparam int RW  = COORD_BITS + 1 + DIST_FRAC_BITS;
  localparam int RCW = $clog2(RW);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIFF, S_MUL, S_RLOAD, S_ROOT, S_DELTA, S_DONE
  } state_e;

  state_e         state_q;
  mul_sel_e       mcnt_q;
  logic [RCW-1:0] rcnt_q;
  logic           out_valid_q;
  logic           commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign commit      = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep      = (state_q == S_PREP);
    cmd_o.diff      = (state_q == S_DIFF);
    cmd_o.mul_en    = (state_q == S_MUL);
    cmd_o.mul_sel   = mcnt_q;
    cmd_o.root_load = (state_q == S_RLOAD);
    cmd_o.root_step = (state_q == S_ROOT);
    cmd_o.delta     = (state_q == S_DELTA);
    cmd_o.commit    = commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcnt_q      <= MS_W;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: state_q <= S_DIFF;
        S_DIFF: begin
          mcnt_q  <= MS_W;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (mcnt_q == MS_SWIPE) begin
            state_q <= S_RLOAD;
          end else begin
            mcnt_q <= mul_sel_e'(mcnt_q + 3'd1);
          end
        end
        S_RLOAD: begin
          rcnt_q  <= RCW'(RW - 1);
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (rcnt_q == '0) begin
            state_q <= S_DELTA;
          end else begin
            rcnt_q <= rcnt_q - 1'b1;
          end
        end
        S_DELTA: state_q <= S_DONE;
        S_DONE: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.prep, cmd_o.diff, cmd_o.mul_en, cmd_o.root_load,
              cmd_o.root_step, cmd_o.delta, cmd_o.commit}))
    else $error("more than one datapath command in a cycle");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed word not presented");

  a_mul_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && mcnt_q == MS_SWIPE) |=> state_q == S_RLOAD)
    else $error("squaring sequence did not hand over to the root");

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PREP && !in_ready_o))
    else $error("accepted word did not start processing");

endmodule

`default_nettype wire

[hdl/tfpsd_datapath.sv]
// Datapath of the detector: frame registers, shared squaring multiplier,
// radix-2 root, gesture decision, gesture state and result register. Uses tfpsd_pkg.
`default_nettype none

module tfpsd_datapath #(
  parameter int COORD_BITS     = 16,
  parameter int DIST_FRAC_BITS = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  tfpsd_pkg::cmd_t              cmd_i,
  input  tfpsd_pkg::cfg_t              cfg_i,
  input  wire signed [COORD_BITS-1:0]  first_x_i,
  input  wire signed [COORD_BITS-1:0]  first_y_i,
  input  wire        [1:0]             first_phase_i,
  input  wire signed [COORD_BITS-1:0]  second_x_i,
  input  wire signed [COORD_BITS-1:0]  second_y_i,
  input  wire        [1:0]             second_phase_i,
  output logic                         pinch_began_o,
  output logic                         pinch_moved_o,
  output logic                         pinch_finished_o,
  output logic signed [COORD_BITS:0]   center_sum_x_o,
  output logic signed [COORD_BITS:0]   center_sum_y_o,
  output logic signed [COORD_BITS:0]   width_change_o,
  output logic signed [COORD_BITS:0]   height_change_o,
  output logic [2:0]                   swipe_dir_o
);
  import tfpsd_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int F   = DIST_FRAC_BITS;
  localparam int RW  = CB + 1 + F;
  localparam int RMW = RW + 3;
  localparam int SW  = 2 * RW;
  localparam int SQP = 2 * CB + 2;
  localparam int MW  = (CB + 2 > SwpW) ? CB + 2 : SwpW;
  localparam int AW  = 2 * MW + 2;
  localparam int DW  = (RW > ThrW + F) ? RW : ThrW + F;

  // frame
  logic signed [CB-1:0] x0_q, y0_q, x1_q, y1_q;
  logic                 rel_q, prs_q;
  logic        [CB-1:0] w_q, h_q;
  logic signed [CB:0]   cx_q, cy_q;
  logic signed [CB+1:0] dx_q, dy_q;
  logic        [CB+1:0] adx_q, ady_q;

  // squares
  logic [2*MW-1:0] prod_q;
  logic [2*MW-1:0] prod_d;
  logic [MW-1:0]   op;
  mul_sel_e        tag_q;
  logic            pvld_q;
  logic [AW-1:0]   sq_q, trav_q, spc_q, lim_q;

  // root
  logic [SW-1:0]   s_q;
  logic [RW-1:0]   r_q;
  logic [RMW-1:0]  rem_q;
  logic [RMW-1:0]  rem_sh, trial;
  logic [RW-1:0]   start_eff;
  logic [RW-1:0]   delta_q;

  // gesture state
  logic                 active_q, armed_q;
  logic [RW-1:0]        start_q;
  logic [CB-1:0]        prior_w_q, prior_h_q;
  logic signed [CB:0]   orig_x_q, orig_y_q;

  // result
  logic                 began_q, moved_q, finished_q;
  logic signed [CB:0]   ox_q, oy_q, dwo_q, dho_q;
  dir_e                 dir_q;

  // decision
  logic               close, began, act_new, armed_eff, fire, armed_new;
  logic [DW-1:0]      thr_sh;
  logic signed [CB:0] ddx, ddy, aw, ah, dw, dh;
  logic signed [CB+1:0] ndx, ndy;
  dir_e               dir;

  assign ddx = (CB+1)'(x1_q) - (CB+1)'(x0_q);
  assign ddy = (CB+1)'(y1_q) - (CB+1)'(y0_q);
  assign aw  = ddx[CB] ? -ddx : ddx;
  assign ah  = ddy[CB] ? -ddy : ddy;
  assign ndx = (CB+2)'(cx_q) - (CB+2)'(orig_x_q);
  assign ndy = (CB+2)'(cy_q) - (CB+2)'(orig_y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q  <= first_x_i;
      y0_q  <= first_y_i;
      x1_q  <= second_x_i;
      y1_q  <= second_y_i;
      rel_q <= (first_phase_i == PH_RELEASED) || (second_phase_i == PH_RELEASED);
      prs_q <= (first_phase_i == PH_PRESSED) || (second_phase_i == PH_PRESSED);
    end
    if (cmd_i.prep) begin
      w_q  <= aw[CB-1:0];
      h_q  <= ah[CB-1:0];
      cx_q <= (CB+1)'(x0_q) + (CB+1)'(x1_q);
      cy_q <= (CB+1)'(y0_q) + (CB+1)'(y1_q);
    end
    if (cmd_i.diff) begin
      dx_q  <= ndx;
      dy_q  <= ndy;
      adx_q <= ndx[CB+1] ? -ndx : ndx;
      ady_q <= ndy[CB+1] ? -ndy : ndy;
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_W:       op = MW'(w_q);
      MS_H:       op = MW'(h_q);
      MS_DX:      op = MW'(adx_q);
      MS_DY:      op = MW'(ady_q);
      MS_SPACING: op = MW'(cfg_i.swipe_max_spacing);
      MS_SWIPE:   op = MW'(cfg_i.swipe_threshold);
      default:    op = '0;
    endcase
  end

  assign prod_d = op * op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      tag_q  <= cmd_i.mul_sel;
    end
    if (pvld_q) begin
      unique case (tag_q)
        MS_W:       sq_q   <= AW'(prod_q);
        MS_H:       sq_q   <= sq_q + AW'(prod_q);
        MS_DX:      trav_q <= AW'(prod_q);
        MS_DY:      trav_q <= trav_q + AW'(prod_q);
        MS_SPACING: spc_q  <= AW'(prod_q);
        MS_SWIPE:   lim_q  <= AW'(prod_q) << 2;
        default:    lim_q  <= lim_q;
      endcase
    end
  end

  assign rem_sh    = {rem_q[RMW-3:0], s_q[SW-1:SW-2]};
  assign trial     = RMW'({r_q, 2'b01});
  assign start_eff = prs_q ? r_q : start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      s_q   <= SW'(sq_q[SQP-1:0]) << (2 * F);
      r_q   <= '0;
      rem_q <= '0;
    end else if (cmd_i.root_step) begin
      s_q <= s_q << 2;
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        r_q   <= {r_q[RW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        r_q   <= {r_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.delta) begin
      delta_q <= (r_q > start_eff) ? r_q - start_eff : start_eff - r_q;
    end
  end

  assign close     = sq_q < spc_q;
  assign thr_sh    = DW'(cfg_i.pinch_threshold) << F;
  assign began     = !rel_q && !active_q && (DW'(delta_q) > thr_sh);
  assign act_new   = !rel_q && (active_q || began);
  assign armed_eff = prs_q ? close : armed_q;
  assign fire      = !rel_q && armed_eff && close && !prs_q && (trav_q > lim_q);
  assign armed_new = !rel_q && armed_eff && close && !fire;
  assign dw        = began ? '0 : $signed({1'b0, w_q}) - $signed({1'b0, prior_w_q});
  assign dh        = began ? '0 : $signed({1'b0, h_q}) - $signed({1'b0, prior_h_q});

  always_comb begin
    if (!fire) begin
      dir = DIR_NONE;
    end else if (adx_q > ady_q) begin
      dir = (!dx_q[CB+1] && dx_q != '0) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      dir = (!dy_q[CB+1] && dy_q != '0) ? DIR_DOWN : DIR_UP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      armed_q   <= 1'b0;
      start_q   <= '0;
      prior_w_q <= '0;
      prior_h_q <= '0;
      orig_x_q  <= '0;
      orig_y_q  <= '0;
    end else if (cmd_i.commit) begin
      active_q <= act_new;
      armed_q  <= armed_new;
      if (!rel_q && prs_q) begin
        start_q  <= r_q;
        orig_x_q <= cx_q;
        orig_y_q <= cy_q;
      end
      if (act_new) begin
        prior_w_q <= w_q;
        prior_h_q <= h_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      began_q    <= began;
      moved_q    <= act_new;
      finished_q <= rel_q && active_q;
      ox_q       <= act_new ? cx_q : '0;
      oy_q       <= act_new ? cy_q : '0;
      dwo_q      <= act_new ? dw : '0;
      dho_q      <= act_new ? dh : '0;
      dir_q      <= dir;
    end
  end

  assign pinch_began_o    = began_q;
  assign pinch_moved_o    = moved_q;
  assign pinch_finished_o = finished_q;
  assign center_sum_x_o   = ox_q;
  assign center_sum_y_o   = oy_q;
  assign width_change_o   = dwo_q;
  assign height_change_o  = dho_q;
  assign swipe_dir_o      = dir_q;

  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && fire) |=> !armed_q)
    else $error("swipe stayed armed after firing");

  a_began_activates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && began) |=> (active_q && pinch_moved_o))
    else $error("pinch start did not activate the pinch");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && rel_q) |=> (!active_q && !armed_q && swipe_dir_o == DIR_NONE))
    else $error("release frame left gesture state set");

  a_product_tagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pvld_q |-> $past(cmd_i.mul_en))
    else $error("product accumulated without a multiply");

endmodule

`default_nettype wire

[hdl/two_finger_pinch_swipe_detector.sv]
// Two-finger pinch and swipe detector top level: configuration registers,
// controller and datapath. Uses tfpsd_pkg, tfpsd_ctrl and tfpsd_datapath.
// Each word passes through accept, geometry, the 6 squarings on one multiplier, the
// one-bit-per-cycle root, the decision and the result handoff, in that order.
// A new word is accepted only once the previous one has been committed to the result register.
// Reset clears gesture state and loads thresholds 10, 120 and 80; no clearing pass.
`default_nettype none

module two_finger_pinch_swipe_detector #(
  parameter int COORD_BITS     = 16,
  parameter int DIST_FRAC_BITS = 4
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [tfpsd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire [tfpsd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire signed [COORD_BITS-1:0]         first_x_i,
  input  wire signed [COORD_BITS-1:0]         first_y_i,
  input  wire        [1:0]                    first_phase_i,
  input  wire signed [COORD_BITS-1:0]         second_x_i,
  input  wire signed [COORD_BITS-1:0]         second_y_i,
  input  wire        [1:0]                    second_phase_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic                                pinch_began_o,
  output logic                                pinch_moved_o,
  output logic                                pinch_finished_o,
  output logic signed [COORD_BITS:0]          center_sum_x_o,
  output logic signed [COORD_BITS:0]          center_sum_y_o,
  output logic signed [COORD_BITS:0]          width_change_o,
  output logic signed [COORD_BITS:0]          height_change_o,
  output logic [2:0]                          swipe_dir_o
);
  import tfpsd_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pinch_threshold   <= PinchThrRst;
      cfg_q.swipe_max_spacing <= SpacingRst;
      cfg_q.swipe_threshold   <= SwipeThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PINCH_THRESHOLD:   cfg_q.pinch_threshold   <= cfg_data_i[ThrW-1:0];
        CFG_SWIPE_MAX_SPACING: cfg_q.swipe_max_spacing <= cfg_data_i[SpcW-1:0];
        CFG_SWIPE_THRESHOLD:   cfg_q.swipe_threshold   <= cfg_data_i[SwpW-1:0];
        default:               cfg_q                   <= cfg_q;
      endcase
    end
  end

  tfpsd_ctrl #(
    .COORD_BITS     (COORD_BITS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  tfpsd_datapath #(
    .COORD_BITS     (COORD_BITS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg_q),
    .first_x_i        (first_x_i),
    .first_y_i        (first_y_i),
    .first_phase_i    (first_phase_i),
    .second_x_i       (second_x_i),
    .second_y_i       (second_y_i),
    .second_phase_i   (second_phase_i),
    .pinch_began_o    (pinch_began_o),
    .pinch_moved_o    (pinch_moved_o),
    .pinch_finished_o (pinch_finished_o),
    .center_sum_x_o   (center_sum_x_o),
    .center_sum_y_o   (center_sum_y_o),
    .width_change_o   (width_change_o),
    .height_change_o  (height_change_o),
    .swipe_dir_o      (swipe_dir_o)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for two_finger_pinch_swipe_detector: directed and random touch frames.
// Predicts each report in-bench and compares it with the block's output words in order.
// Depends on tfpsd_pkg and the detector top level only.
`default_nettype none

module tb;
  import tfpsd_pkg::*;

  localparam int CW         = 16;
  localparam int FRAC       = 4;
  localparam int CoordMax   = 2 ** (CW - 1) - 1;
  localparam int CoordMin   = -(2 ** (CW - 1));
  localparam int StallLimit = 4000;

  typedef struct {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    phase_e               first_phase;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    phase_e               second_phase;
  } touch_frame_t;

  typedef struct {
    logic               began;
    logic               moved;
    logic               finished;
    logic signed [CW:0] center_x;
    logic signed [CW:0] center_y;
    logic signed [CW:0] width_change;
    logic signed [CW:0] height_change;
    dir_e               dir;
  } gesture_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [CW-1:0] first_x_i = '0;
  logic signed [CW-1:0] first_y_i = '0;
  logic [1:0]           first_phase_i = '0;
  logic signed [CW-1:0] second_x_i = '0;
  logic signed [CW-1:0] second_y_i = '0;
  logic [1:0]           second_phase_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 pinch_began_o;
  logic                 pinch_moved_o;
  logic                 pinch_finished_o;
  logic signed [CW:0]   center_sum_x_o;
  logic signed [CW:0]   center_sum_y_o;
  logic signed [CW:0]   width_change_o;
  logic signed [CW:0]   height_change_o;
  logic [2:0]           swipe_dir_o;

  two_finger_pinch_swipe_detector #(
    .COORD_BITS    (CW),
    .DIST_FRAC_BITS(FRAC)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .first_phase_i   (first_phase_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .second_phase_i  (second_phase_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pinch_began_o   (pinch_began_o),
    .pinch_moved_o   (pinch_moved_o),
    .pinch_finished_o(pinch_finished_o),
    .center_sum_x_o  (center_sum_x_o),
    .center_sum_y_o  (center_sum_y_o),
    .width_change_o  (width_change_o),
    .height_change_o (height_change_o),
    .swipe_dir_o     (swipe_dir_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Gesture tracker state and register copies
  longint unsigned cfg_pinch_thr = PinchThrRst;
  longint unsigned cfg_spacing   = SpacingRst;
  longint unsigned cfg_swipe_thr = SwipeThrRst;
  bit              pinch_on      = 1'b0;
  bit              swipe_on      = 1'b0;
  longint unsigned start_dist    = 0;
  longint          last_w        = 0;
  longint          last_h        = 0;
  longint          origin_x      = 0;
  longint          origin_y      = 0;

  gesture_report_t pending_reports[$];
  gesture_report_t want;

  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned hold_request    = 0;
  int unsigned hold_left       = 0;
  int unsigned stall_cycles    = 0;
  int unsigned mismatch_count  = 0;
  int unsigned frames_sent     = 0;
  int unsigned reports_checked = 0;
  int unsigned pinch_starts    = 0;
  int unsigned swipes_fired    = 0;
  int unsigned settings_used   = 0;

  function automatic longint unsigned fixed_root(longint unsigned s);
    longint unsigned r;
    longint unsigned rem;
    longint unsigned trial;
    int              i;
    r   = 0;
    rem = 0;
    for (i = 0; i < 32 + FRAC; i++) begin
      rem = rem << 2;
      if (i < 32) rem = rem | ((s >> (2 * (31 - i))) & 64'd3);
      trial = (r << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r   = (r << 1) | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic gesture_report_t predict_report(touch_frame_t f);
    gesture_report_t r;
    longint          x0, y0, x1, y1, w, h, cx, cy, dx, dy, dw, dh;
    longint unsigned sq, spc_sq, root_dist, delta, adx, ady, travel, lim;
    r.began         = 1'b0;
    r.moved         = 1'b0;
    r.finished      = 1'b0;
    r.center_x      = '0;
    r.center_y      = '0;
    r.width_change  = '0;
    r.height_change = '0;
    r.dir           = DIR_NONE;
    if (f.first_phase == PH_RELEASED || f.second_phase == PH_RELEASED) begin
      r.finished = pinch_on;
      pinch_on   = 1'b0;
      swipe_on   = 1'b0;
      return r;
    end
    x0        = f.first_x;
    y0        = f.first_y;
    x1        = f.second_x;
    y1        = f.second_y;
    w         = (x1 > x0) ? x1 - x0 : x0 - x1;
    h         = (y1 > y0) ? y1 - y0 : y0 - y1;
    cx        = x0 + x1;
    cy        = y0 + y1;
    sq        = w * w + h * h;
    spc_sq    = cfg_spacing * cfg_spacing;
    root_dist = fixed_root(sq);
    if (f.first_phase == PH_PRESSED || f.second_phase == PH_PRESSED) begin
      start_dist = root_dist;
      swipe_on   = (sq < spc_sq);
      origin_x   = cx;
      origin_y   = cy;
    end
    if (!pinch_on) begin
      delta = (root_dist > start_dist) ? root_dist - start_dist : start_dist - root_dist;
      if (delta > (cfg_pinch_thr << FRAC)) begin
        pinch_on = 1'b1;
        last_w   = w;
        last_h   = h;
        r.began  = 1'b1;
      end
    end
    if (pinch_on) begin
      dw              = w - last_w;
      dh              = h - last_h;
      last_w          = w;
      last_h          = h;
      r.moved         = 1'b1;
      r.center_x      = cx[CW:0];
      r.center_y      = cy[CW:0];
      r.width_change  = dw[CW:0];
      r.height_change = dh[CW:0];
    end
    if (swipe_on) begin
      if (!(sq < spc_sq)) begin
        swipe_on = 1'b0;
      end else begin
        dx     = cx - origin_x;
        dy     = cy - origin_y;
        adx    = (dx < 0) ? -dx : dx;
        ady    = (dy < 0) ? -dy : dy;
        travel = adx * adx + ady * ady;
        lim    = 4 * cfg_swipe_thr * cfg_swipe_thr;
        if (travel > lim) begin
          if (adx > ady) begin
            if (dx > 0) r.dir = DIR_RIGHT;
            else r.dir = DIR_LEFT;
          end else begin
            if (dy > 0) r.dir = DIR_DOWN;
            else r.dir = DIR_UP;
          end
          swipe_on = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clip(int v);
    if (v > CoordMax) v = CoordMax;
    else if (v < CoordMin) v = CoordMin;
    return v[CW-1:0];
  endfunction

  function automatic int rand_span(int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  function automatic touch_frame_t make_frame(int x0, int y0, phase_e p0,
                                              int x1, int y1, phase_e p1);
    touch_frame_t f;
    f.first_x      = clip(x0);
    f.first_y      = clip(y0);
    f.first_phase  = p0;
    f.second_x     = clip(x1);
    f.second_y     = clip(y1);
    f.second_phase = p1;
    return f;
  endfunction

  function automatic touch_frame_t noise_frame();
    touch_frame_t f;
    f.first_x      = CW'($urandom());
    f.first_y      = CW'($urandom());
    f.first_phase  = phase_e'($urandom_range(3));
    f.second_x     = CW'($urandom());
    f.second_y     = CW'($urandom());
    f.second_phase = phase_e'($urandom_range(3));
    return f;
  endfunction

  function automatic phase_e live_phase();
    if ($urandom_range(19) == 0) return PH_PRESSED;
    if ($urandom_range(1) == 0) return PH_MOVED;
    return PH_STATIONARY;
  endfunction

  task automatic send_frame(touch_frame_t f);
    gesture_report_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_x_i      <= f.first_x;
    first_y_i      <= f.first_y;
    first_phase_i  <= f.first_phase;
    second_x_i     <= f.second_x;
    second_y_i     <= f.second_y;
    second_phase_i <= f.second_phase;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_report(f);
    pending_reports = {pending_reports, r};
    frames_sent++;
    if (r.began) pinch_starts++;
    if (r.dir != DIR_NONE) swipes_fired++;
  endtask

  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_PINCH_THRESHOLD:   cfg_pinch_thr = value & ((1 << ThrW) - 1);
      CFG_SWIPE_MAX_SPACING: cfg_spacing   = value & ((1 << SpcW) - 1);
      CFG_SWIPE_THRESHOLD:   cfg_swipe_thr = value & ((1 << SwpW) - 1);
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned thr, int unsigned spc, int unsigned swp);
    drain_reports();
    write_reg(CFG_PINCH_THRESHOLD, thr);
    write_reg(CFG_SWIPE_MAX_SPACING, spc);
    write_reg(CFG_SWIPE_THRESHOLD, swp);
    settings_used++;
  endtask

  // One press, a run of moves, then usually a lift; some start without a press
  task automatic play_gesture(output int unsigned n);
    int     cx, cy, hx, hy, vx, vy, steps, i, reach, spread;
    bit     wide;
    phase_e p0, p1;
    n      = 0;
    wide   = ($urandom_range(3) == 0);
    reach  = wide ? 32767 : 2000;
    spread = wide ? 32767 : 150;
    cx     = rand_span(reach);
    cy     = rand_span(reach);
    hx     = rand_span(spread);
    hy     = rand_span(spread);
    if ($urandom_range(9) != 0) begin
      case ($urandom_range(2))
        0: begin p0 = PH_PRESSED; p1 = PH_PRESSED; end
        1: begin p0 = PH_PRESSED; p1 = live_phase(); end
        default: begin p0 = live_phase(); p1 = PH_PRESSED; end
      endcase
    end else begin
      p0 = PH_MOVED;
      p1 = PH_STATIONARY;
    end
    send_frame(make_frame(cx - hx, cy - hy, p0, cx + hx, cy + hy, p1));
    n++;
    steps = $urandom_range(1, 10);
    vx    = rand_span(wide ? 3000 : 60);
    vy    = rand_span(wide ? 3000 : 60);
    for (i = 0; i < steps; i++) begin
      cx = int'(clip(cx + vx));
      cy = int'(clip(cy + vy));
      hx = hx + rand_span(wide ? 2000 : 20);
      hy = hy + rand_span(wide ? 2000 : 20);
      send_frame(make_frame(cx - hx, cy - hy, live_phase(), cx + hx, cy + hy, live_phase()));
      n++;
    end
    if ($urandom_range(4) != 0) begin
      case ($urandom_range(2))
        0: begin p0 = PH_RELEASED; p1 = PH_RELEASED; end
        1: begin p0 = PH_RELEASED; p1 = live_phase(); end
        default: begin p0 = live_phase(); p1 = PH_RELEASED; end
      endcase
      send_frame(make_frame(cx - hx, cy - hy, p0, cx + hx, cy + hy, p1));
      n++;
    end
  endtask

  task automatic play_random_frames(int unsigned count);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_frame(noise_frame());
        sent++;
      end else begin
        play_gesture(n);
        sent += n;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 10;
    recv_idle_pct = 78;
    send_frame(make_frame(0, 0, PH_RELEASED, 0, 0, PH_RELEASED));
    // start from zero distance without any press
    send_frame(make_frame(0, 0, PH_MOVED, 300, 0, PH_STATIONARY));
    send_frame(make_frame(-10, 0, PH_MOVED, 310, 400, PH_MOVED));
    send_frame(make_frame(0, 0, PH_STATIONARY, 0, 0, PH_RELEASED));
    send_frame(make_frame(100, 100, PH_PRESSED, 100, 100, PH_RELEASED));
    // distance change exactly at the threshold, then one past it
    send_frame(make_frame(0, 0, PH_PRESSED, 0, 0, PH_PRESSED));
    send_frame(make_frame(0, 0, PH_MOVED, 10, 0, PH_MOVED));
    send_frame(make_frame(0, 0, PH_MOVED, 11, 0, PH_MOVED));
    send_frame(make_frame(0, 0, PH_RELEASED, 0, 0, PH_MOVED));
    send_frame(make_frame(0, 0, PH_PRESSED, 20, 0, PH_MOVED));
    send_frame(make_frame(100, 0, PH_MOVED, 120, 0, PH_MOVED));
    send_frame(make_frame(0, 0, PH_PRESSED, 20, 0, PH_PRESSED));
    send_frame(make_frame(-100, 0, PH_MOVED, -80, 0, PH_MOVED));
    send_frame(make_frame(0, 0, PH_PRESSED, 0, 20, PH_STATIONARY));
    send_frame(make_frame(0, 100, PH_MOVED, 0, 120, PH_MOVED));
    send_frame(make_frame(0, 0, PH_STATIONARY, 0, 20, PH_PRESSED));
    send_frame(make_frame(0, -100, PH_MOVED, 0, -80, PH_MOVED));
    // equal travel on both axes
    send_frame(make_frame(0, 0, PH_PRESSED, 20, 0, PH_MOVED));
    send_frame(make_frame(100, 100, PH_MOVED, 120, 100, PH_MOVED));
    send_frame(make_frame(0, 0, PH_PRESSED, 120, 0, PH_STATIONARY));
    send_frame(make_frame(CoordMin, CoordMin, PH_PRESSED, CoordMax, CoordMax, PH_PRESSED));
    send_frame(make_frame(CoordMax, CoordMax, PH_MOVED, CoordMin, CoordMin, PH_MOVED));
    send_frame(make_frame(CoordMax, CoordMin, PH_MOVED, CoordMax, CoordMax, PH_STATIONARY));
    send_frame(make_frame(CoordMin, CoordMax, PH_MOVED, CoordMax, CoordMin, PH_MOVED));
    send_frame(make_frame(CoordMin, CoordMin, PH_STATIONARY, CoordMin, CoordMin, PH_MOVED));
    send_frame(make_frame(0, 0, PH_RELEASED, 0, 0, PH_RELEASED));
  endtask

  task automatic test_loose_thresholds();
    send_idle_pct = 10;
    recv_idle_pct = 78;
    apply_settings(0, (1 << SpcW) - 1, 0);
    play_random_frames(125);
  endtask

  task automatic test_strict_thresholds();
    send_idle_pct = 10;
    recv_idle_pct = 78;
    apply_settings((1 << ThrW) - 1, 0, (1 << SwpW) - 1);
    play_random_frames(125);
  endtask

  task automatic test_random_settings();
    int unsigned k;
    send_idle_pct = 78;
    recv_idle_pct = 10;
    for (k = 0; k < 2; k++) begin
      apply_settings($urandom_range(40), $urandom_range(40, 400), $urandom_range(5, 200));
      play_random_frames(125);
    end
  endtask

  task automatic test_default_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(PinchThrRst, SpacingRst, SwipeThrRst);
    play_random_frames(125);
    apply_settings($urandom_range((1 << ThrW) - 1), $urandom_range((1 << SpcW) - 1),
                   $urandom_range((1 << SwpW) - 1));
    play_random_frames(125);
  endtask

  task automatic test_output_backpressure();
    drain_reports();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 600;
    play_random_frames(24);
  endtask

  // Check each output word; drive the output ready with idling and hold-offs
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_checked++;
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report word at %0t", $realtime);
      end else begin
        want = pending_reports.pop_front();
        if (pinch_began_o !== want.began || pinch_moved_o !== want.moved ||
            pinch_finished_o !== want.finished || center_sum_x_o !== want.center_x ||
            center_sum_y_o !== want.center_y || width_change_o !== want.width_change ||
            height_change_o !== want.height_change || swipe_dir_o !== want.dir) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"report %0d mismatch: expected b%0b m%0b f%0b c(%0d,%0d) d(%0d,%0d)",
                      " dir %0d, got b%0b m%0b f%0b c(%0d,%0d) d(%0d,%0d) dir %0d"},
                     reports_checked, want.began, want.moved, want.finished,
                     want.center_x, want.center_y, want.width_change,
                     want.height_change, want.dir, pinch_began_o, pinch_moved_o,
                     pinch_finished_o, center_sum_x_o, center_sum_y_o,
                     width_change_o, height_change_o, swipe_dir_o);
        end
      end
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_loose_thresholds();
    test_strict_thresholds();
    test_random_settings();
    test_default_settings();
    test_output_backpressure();
    drain_reports();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d touch frames under %0d register settings, checked %0d reports.",
             frames_sent, settings_used, reports_checked);
    $display("Predicted %0d pinch starts and %0d swipes; %0d mismatches, %0d reports missing.",
             pinch_starts, swipes_fired, mismatch_count, pending_reports.size());
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/tfpsd_pkg.sv
hdl/tfpsd_ctrl.sv
hdl/tfpsd_datapath.sv
hdl/two_finger_pinch_swipe_detector.sv
tb/tb.sv
